[design/i2cbb_pkg.sv]
// ----------------------------------------------------------------------------
// I2C bit-bang master package
// Holds the command codes, register indexes, reset values and the sequencer
// phase type that the I2C master uses.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

    localparam int unsigned CfgWidth  = 8;
    localparam int unsigned InWidth   = 16;
    localparam int unsigned OutWidth  = 16;
    localparam int unsigned AddrWidth = 5;
    localparam int unsigned DataWidth = 32;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_START    = 3'd1,
        ACT_STOP     = 3'd2,
        ACT_WRITE    = 3'd3,
        ACT_READ     = 3'd4,
        ACT_WAIT_ACK = 3'd5,
        ACT_ACK_BIT  = 3'd6
    } action_t;

    localparam logic [2:0] REG_HOLD        = 3'd0;
    localparam logic [2:0] REG_WRITE_HALF  = 3'd1;
    localparam logic [2:0] REG_READ_HALF   = 3'd2;
    localparam logic [2:0] REG_ACK_WAIT    = 3'd3;
    localparam logic [2:0] REG_ACK_TIMEOUT = 3'd4;
    localparam logic [2:0] REG_ACK_RELEASE = 3'd5;

    localparam logic [CfgWidth-1:0] HOLD_RESET        = 8'd14;
    localparam logic [CfgWidth-1:0] WRITE_HALF_RESET  = 8'd15;
    localparam logic [CfgWidth-1:0] READ_HALF_RESET   = 8'd50;
    localparam logic [CfgWidth-1:0] ACK_WAIT_RESET    = 8'd14;
    localparam logic [CfgWidth-1:0] ACK_TIMEOUT_RESET = 8'd250;
    localparam logic [CfgWidth-1:0] ACK_RELEASE_RESET = 8'd10;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [7:0] POLL_MAX      = 8'd255;

    typedef enum logic [14:0] {
        PH_IDLE    = 15'b000000000000001,
        PH_ST1     = 15'b000000000000010,
        PH_ST2     = 15'b000000000000100,
        PH_SP1     = 15'b000000000001000,
        PH_SP2     = 15'b000000000010000,
        PH_WR_LOW  = 15'b000000000100000,
        PH_WR_HIGH = 15'b000000001000000,
        PH_RD_LOW  = 15'b000000010000000,
        PH_RD_HIGH = 15'b000000100000000,
        PH_AK_LOW  = 15'b000001000000000,
        PH_AK_HIGH = 15'b000010000000000,
        PH_WA_LOW  = 15'b000100000000000,
        PH_WA_HIGH = 15'b001000000000000,
        PH_WA_POLL = 15'b010000000000000,
        PH_WA_REL  = 15'b100000000000000
    } phase_t;

endpackage

[design/i2c_bitbang_master.sv]
// ----------------------------------------------------------------------------
// I2C bit-bang master
// Steps an I2C command sequencer by one tick for every input transaction and
// returns the bus drive levels and status for that tick.
// ----------------------------------------------------------------------------
// The result of a tick is registered and appears on the output in the cycle after its
// transaction is accepted. Throughput: one transaction per cycle while m_tready does not
// stall the output register, set by the single sequencer state update between the input
// and the output register. The output register frees the input side whenever its result is taken.
// Reset clears the sequencer to idle with SCL and SDA released high, SDA
// driven, and all configuration registers at their default tick counts.
module i2c_bitbang_master (
    input  logic                                clk,
    input  logic                                rst_n,
    // action[2:0], tx_byte[10:3], send_ack[11], sda_in[12], zero[15:13]
    input  logic [i2cbb_pkg::InWidth-1:0]       s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // scl_level[0], sda_level[1], sda_is_output[2], busy_res[3], done_res[4],
    // rx_byte[12:5], ack_failed[13], zero[15:14]
    output logic [i2cbb_pkg::OutWidth-1:0]      m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [i2cbb_pkg::AddrWidth-1:0]     paddr,
    input  logic [i2cbb_pkg::DataWidth-1:0]     pwdata,
    output logic [i2cbb_pkg::DataWidth-1:0]     prdata,
    output logic                                pready
);

    logic [7:0] hold_reg, write_half_reg, read_half_reg;
    logic [7:0] ack_wait_reg, ack_timeout_reg, ack_release_reg;

    i2cbb_pkg::phase_t phase_reg, phase_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] delay_reg, delay_next;
    logic [7:0] timeout_reg, timeout_next;
    logic       ack_choice_reg, ack_choice_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       sda_dir_reg, sda_dir_next;
    logic       fail_reg, fail_next;
    logic [7:0] rx_hold_reg, rx_hold_next;

    logic [i2cbb_pkg::OutWidth-1:0] out_data_reg;
    logic                           out_valid_reg;

    logic [2:0] in_action;
    logic [7:0] in_tx_byte;
    logic       in_send_ack;
    logic       in_sda;
    logic       accept;
    logic       cfg_write;
    logic       expired;
    logic [7:0] delay_dec;
    logic [3:0] bit_count_inc;
    logic [7:0] shift_rd;
    logic [7:0] timeout_inc;
    logic       done;

    assign in_action   = s_tdata[2:0];
    assign in_tx_byte  = s_tdata[10:3];
    assign in_send_ack = s_tdata[11];
    assign in_sda      = s_tdata[12];

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg        <= i2cbb_pkg::HOLD_RESET;
            write_half_reg  <= i2cbb_pkg::WRITE_HALF_RESET;
            read_half_reg   <= i2cbb_pkg::READ_HALF_RESET;
            ack_wait_reg    <= i2cbb_pkg::ACK_WAIT_RESET;
            ack_timeout_reg <= i2cbb_pkg::ACK_TIMEOUT_RESET;
            ack_release_reg <= i2cbb_pkg::ACK_RELEASE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                i2cbb_pkg::REG_HOLD:        hold_reg        <= pwdata[7:0];
                i2cbb_pkg::REG_WRITE_HALF:  write_half_reg  <= pwdata[7:0];
                i2cbb_pkg::REG_READ_HALF:   read_half_reg   <= pwdata[7:0];
                i2cbb_pkg::REG_ACK_WAIT:    ack_wait_reg    <= pwdata[7:0];
                i2cbb_pkg::REG_ACK_TIMEOUT: ack_timeout_reg <= pwdata[7:0];
                i2cbb_pkg::REG_ACK_RELEASE: ack_release_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            i2cbb_pkg::REG_HOLD:        prdata = {24'd0, hold_reg};
            i2cbb_pkg::REG_WRITE_HALF:  prdata = {24'd0, write_half_reg};
            i2cbb_pkg::REG_READ_HALF:   prdata = {24'd0, read_half_reg};
            i2cbb_pkg::REG_ACK_WAIT:    prdata = {24'd0, ack_wait_reg};
            i2cbb_pkg::REG_ACK_TIMEOUT: prdata = {24'd0, ack_timeout_reg};
            i2cbb_pkg::REG_ACK_RELEASE: prdata = {24'd0, ack_release_reg};
            default:                    prdata = '0;
        endcase
    end

    // A hold of n ticks counts the tick on which the levels were set.
    assign expired       = (delay_reg <= 8'd1);
    assign delay_dec     = expired ? 8'd0 : delay_reg - 8'd1;
    assign bit_count_inc = bit_count_reg + 4'd1;
    assign shift_rd      = {shift_reg[6:0], in_sda};
    assign timeout_inc   = (timeout_reg == i2cbb_pkg::POLL_MAX) ? timeout_reg
                                                                : timeout_reg + 8'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        delay_next      = delay_dec;
        timeout_next    = timeout_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        sda_dir_next    = sda_dir_reg;
        fail_next       = fail_reg;
        rx_hold_next    = rx_hold_reg;
        done            = 1'b0;

        unique case (phase_reg)
            i2cbb_pkg::PH_IDLE:
            begin
                delay_next = delay_reg;
                if (in_action != i2cbb_pkg::ACT_NONE && in_action <= i2cbb_pkg::ACT_ACK_BIT)
                begin
                    fail_next = 1'b0;
                end
                unique case (in_action)
                    i2cbb_pkg::ACT_START:
                    begin
                        sda_dir_next = 1'b1;
                        sda_next     = 1'b1;
                        scl_next     = 1'b1;
                        delay_next   = hold_reg;
                        phase_next   = i2cbb_pkg::PH_ST1;
                    end
                    i2cbb_pkg::ACT_STOP:
                    begin
                        sda_dir_next = 1'b1;
                        scl_next     = 1'b0;
                        sda_next     = 1'b0;
                        delay_next   = hold_reg;
                        phase_next   = i2cbb_pkg::PH_SP1;
                    end
                    i2cbb_pkg::ACT_WRITE:
                    begin
                        sda_dir_next   = 1'b1;
                        scl_next       = 1'b0;
                        bit_count_next = 4'd0;
                        sda_next       = in_tx_byte[7];
                        shift_next     = {in_tx_byte[6:0], 1'b0};
                        delay_next     = write_half_reg;
                        phase_next     = i2cbb_pkg::PH_WR_LOW;
                    end
                    i2cbb_pkg::ACT_READ:
                    begin
                        sda_dir_next    = 1'b0;
                        scl_next        = 1'b0;
                        shift_next      = 8'd0;
                        bit_count_next  = 4'd0;
                        ack_choice_next = in_send_ack;
                        delay_next      = read_half_reg;
                        phase_next      = i2cbb_pkg::PH_RD_LOW;
                    end
                    i2cbb_pkg::ACT_WAIT_ACK:
                    begin
                        scl_next     = 1'b0;
                        sda_next     = 1'b1;
                        sda_dir_next = 1'b0;
                        timeout_next = 8'd0;
                        delay_next   = ack_wait_reg;
                        phase_next   = i2cbb_pkg::PH_WA_LOW;
                    end
                    i2cbb_pkg::ACT_ACK_BIT:
                    begin
                        ack_choice_next = in_send_ack;
                        scl_next        = 1'b0;
                        sda_dir_next    = 1'b1;
                        sda_next        = !in_send_ack;
                        delay_next      = write_half_reg;
                        phase_next      = i2cbb_pkg::PH_AK_LOW;
                    end
                    default: ;
                endcase
            end
            i2cbb_pkg::PH_ST1:
            begin
                if (expired)
                begin
                    sda_next   = 1'b0;
                    delay_next = hold_reg;
                    phase_next = i2cbb_pkg::PH_ST2;
                end
            end
            i2cbb_pkg::PH_ST2:
            begin
                if (expired)
                begin
                    scl_next   = 1'b0;
                    phase_next = i2cbb_pkg::PH_IDLE;
                    done       = 1'b1;
                end
            end
            i2cbb_pkg::PH_SP1:
            begin
                if (expired)
                begin
                    scl_next   = 1'b1;
                    delay_next = hold_reg;
                    phase_next = i2cbb_pkg::PH_SP2;
                end
            end
            i2cbb_pkg::PH_SP2:
            begin
                if (expired)
                begin
                    sda_next   = 1'b1;
                    phase_next = i2cbb_pkg::PH_IDLE;
                    done       = 1'b1;
                end
            end
            i2cbb_pkg::PH_WR_LOW:
            begin
                if (expired)
                begin
                    scl_next   = 1'b1;
                    delay_next = write_half_reg;
                    phase_next = i2cbb_pkg::PH_WR_HIGH;
                end
            end
            i2cbb_pkg::PH_WR_HIGH:
            begin
                if (expired)
                begin
                    bit_count_next = bit_count_inc;
                    scl_next       = 1'b0;
                    if (bit_count_inc >= i2cbb_pkg::BITS_PER_BYTE)
                    begin
                        phase_next = i2cbb_pkg::PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        delay_next = write_half_reg;
                        phase_next = i2cbb_pkg::PH_WR_LOW;
                    end
                end
            end
            i2cbb_pkg::PH_RD_LOW:
            begin
                if (expired)
                begin
                    scl_next   = 1'b1;
                    delay_next = read_half_reg;
                    phase_next = i2cbb_pkg::PH_RD_HIGH;
                end
            end
            i2cbb_pkg::PH_RD_HIGH:
            begin
                if (expired)
                begin
                    shift_next     = shift_rd;
                    bit_count_next = bit_count_inc;
                    if (bit_count_inc >= i2cbb_pkg::BITS_PER_BYTE)
                    begin
                        rx_hold_next = shift_rd;
                        scl_next     = 1'b0;
                        sda_dir_next = 1'b1;
                        sda_next     = !ack_choice_reg;
                        delay_next   = write_half_reg;
                        phase_next   = i2cbb_pkg::PH_AK_LOW;
                    end
                    else
                    begin
                        scl_next   = 1'b0;
                        delay_next = read_half_reg;
                        phase_next = i2cbb_pkg::PH_RD_LOW;
                    end
                end
            end
            i2cbb_pkg::PH_AK_LOW:
            begin
                if (expired)
                begin
                    scl_next   = 1'b1;
                    delay_next = write_half_reg;
                    phase_next = i2cbb_pkg::PH_AK_HIGH;
                end
            end
            i2cbb_pkg::PH_AK_HIGH:
            begin
                if (expired)
                begin
                    scl_next   = 1'b0;
                    phase_next = i2cbb_pkg::PH_IDLE;
                    done       = 1'b1;
                end
            end
            i2cbb_pkg::PH_WA_LOW:
            begin
                if (expired)
                begin
                    scl_next   = 1'b1;
                    delay_next = ack_wait_reg;
                    phase_next = i2cbb_pkg::PH_WA_HIGH;
                end
            end
            i2cbb_pkg::PH_WA_HIGH,
            i2cbb_pkg::PH_WA_POLL:
            begin
                if (expired)
                begin
                    if (!in_sda)
                    begin
                        scl_next = 1'b0;
                        if (ack_release_reg == 8'd0)
                        begin
                            phase_next = i2cbb_pkg::PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            delay_next = ack_release_reg;
                            phase_next = i2cbb_pkg::PH_WA_REL;
                        end
                    end
                    else
                    begin
                        timeout_next = timeout_inc;
                        if (timeout_inc > ack_timeout_reg)
                        begin
                            // Acknowledge never came: flag it and release the bus with a stop.
                            fail_next    = 1'b1;
                            sda_dir_next = 1'b1;
                            scl_next     = 1'b0;
                            sda_next     = 1'b0;
                            delay_next   = hold_reg;
                            phase_next   = i2cbb_pkg::PH_SP1;
                        end
                        else
                        begin
                            delay_next = 8'd1;
                            phase_next = i2cbb_pkg::PH_WA_POLL;
                        end
                    end
                end
            end
            i2cbb_pkg::PH_WA_REL:
            begin
                if (expired)
                begin
                    phase_next = i2cbb_pkg::PH_IDLE;
                    done       = 1'b1;
                end
            end
            default:
            begin
                phase_next = i2cbb_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= i2cbb_pkg::PH_IDLE;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            delay_reg      <= 8'd0;
            timeout_reg    <= 8'd0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            sda_dir_reg    <= 1'b1;
            fail_reg       <= 1'b0;
            rx_hold_reg    <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                bit_count_reg  <= bit_count_next;
                shift_reg      <= shift_next;
                delay_reg      <= delay_next;
                timeout_reg    <= timeout_next;
                ack_choice_reg <= ack_choice_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                sda_dir_reg    <= sda_dir_next;
                fail_reg       <= fail_next;
                rx_hold_reg    <= rx_hold_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {2'b00, fail_next, rx_hold_next, done,
                             (phase_next != i2cbb_pkg::PH_IDLE),
                             sda_dir_next, sda_next, scl_next};
        end
    end

endmodule
